FILE: rtl/mpgt_pkg.sv
// shared types and constants for the multi-pattern goto table
`timescale 1ns / 1ps

package mpgt_pkg;

  localparam int MAX_NODES_DEF    = 32;
  localparam int NUM_KEYWORDS_DEF = 4;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_BUILD  = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_BUILD  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_BAD    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_PHASE = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] symbol;
    logic       word_end;
    logic [1:0] keyword_index;
    logic [4:0] from_state;
  } item_t;

endpackage

FILE: rtl/mpgt_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mpgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mpgt_front.sv
// request decode and two-entry queue in front of the table engine
`timescale 1ns / 1ps

module mpgt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     req_type,
  input  logic [1:0]     symbol,
  input  logic           word_end,
  input  logic [1:0]     keyword_index,
  input  logic [4:0]     from_state,
  output logic           q_valid,
  output mpgt_pkg::item_t q_item,
  input  logic           q_pop
);

  mpgt_pkg::item_t slots [2];
  mpgt_pkg::item_t dec;
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;
  logic            push;

  always_comb begin
    dec.symbol        = symbol;
    dec.word_end      = word_end;
    dec.keyword_index = keyword_index;
    dec.from_state    = from_state;
    case (req_type)
      mpgt_pkg::REQ_INSERT: dec.op = mpgt_pkg::OP_INSERT;
      mpgt_pkg::REQ_BUILD:  dec.op = mpgt_pkg::OP_BUILD;
      mpgt_pkg::REQ_LOOKUP: dec.op = mpgt_pkg::OP_LOOKUP;
      default:              dec.op = mpgt_pkg::OP_BAD;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= dec;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (q_pop) rptr <= !rptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

FILE: rtl/mpgt_back.sv
// table engine: trie insert, failure link build and lookup
`timescale 1ns / 1ps

module mpgt_back #(
  parameter int MAX_NODES    = mpgt_pkg::MAX_NODES_DEF,
  parameter int NUM_KEYWORDS = mpgt_pkg::NUM_KEYWORDS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  mpgt_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      status,
  output logic [4:0]      next_node,
  output logic [3:0]      match_mask,
  output logic [5:0]      node_count
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int CW    = $clog2(MAX_NODES + 1);
  localparam int SW    = NW + 2;
  localparam int NSLOT = MAX_NODES * 4;
  localparam int NK    = NUM_KEYWORDS;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_INS    = 9'b000000010,
    ST_INS_RD = 9'b000000100,
    ST_LK_RD  = 9'b000001000,
    ST_B_POP  = 9'b000010000,
    ST_B_RD1  = 9'b000100000,
    ST_B_RD2  = 9'b001000000,
    ST_B_ACT  = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  state_t          state;
  mpgt_pkg::item_t it;
  logic [CW-1:0]   nodes_used;
  logic [NW-1:0]   cursor;
  logic            built;
  logic [NSLOT-1:0] gvalid;
  logic [NW-1:0]   fail [MAX_NODES];
  logic [NK-1:0]   emask [MAX_NODES];
  logic [NW-1:0]   queue [MAX_NODES];
  logic [CW-1:0]   head;
  logic [CW-1:0]   tail;
  logic [NW-1:0]   cur;
  logic [1:0]      sidx;
  logic [NW-1:0]   fval;

  mpgt_pkg::status_t res_status;
  logic [NW-1:0]   res_next;
  logic [NK-1:0]   res_mask;

  mpgt_pkg::status_t o_status;
  logic [NW-1:0]   o_next;
  logic [NK-1:0]   o_mask;
  logic [CW-1:0]   o_cnt;

  logic            ram_we;
  logic [SW-1:0]   ram_waddr;
  logic [NW-1:0]   ram_wdata;
  logic [SW-1:0]   ram_raddr;
  logic [NW-1:0]   ram_rdata;

  logic [SW-1:0]   ins_slot;
  logic [SW-1:0]   b_slot;
  logic [SW-1:0]   lk_slot;
  logic [NW-1:0]   ins_nxt;
  logic            full;
  logic            lk_range;
  logic            kidx_ok;
  logic [31:0]     next32;
  logic [31:0]     mask32;
  logic [31:0]     cnt32;

  assign ins_slot = {cursor, it.symbol};
  assign b_slot   = {cur, sidx};
  assign lk_slot  = {NW'(q_item.from_state), q_item.symbol};
  assign ins_nxt  = (state == ST_INS_RD) ? ram_rdata : NW'(nodes_used);
  assign full     = (32'(nodes_used) >= MAX_NODES);
  assign lk_range = (32'(q_item.from_state) >= 32'(nodes_used));
  assign kidx_ok  = (32'(it.keyword_index) < NK);
  assign q_pop    = (state == ST_IDLE) && q_valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = b_slot;
    ram_wdata = fval;
    case (state)
      ST_IDLE:  ram_raddr = lk_slot;
      ST_INS:   ram_raddr = ins_slot;
      ST_B_RD1: ram_raddr = {fail[cur], sidx};
      default:  ram_raddr = b_slot;
    endcase
    if (state == ST_INS && !gvalid[ins_slot] && !full) begin
      ram_we    = 1'b1;
      ram_waddr = ins_slot;
      ram_wdata = NW'(nodes_used);
    end else if (state == ST_B_ACT && !gvalid[b_slot]) begin
      ram_we = 1'b1;
    end
  end

  mpgt_ram #(.WIDTH(NW), .DEPTH(NSLOT)) u_goto (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      nodes_used <= CW'(1);
      cursor     <= '0;
      built      <= 1'b0;
      gvalid     <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < MAX_NODES; i++) begin
        fail[i]  <= '0;
        emask[i] <= '0;
      end
    end else begin
      if (state == ST_EMIT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            it       <= q_item;
            res_next <= '0;
            res_mask <= '0;
            case (q_item.op)
              mpgt_pkg::OP_INSERT: begin
                res_status <= mpgt_pkg::STAT_PHASE;
                if (!built) state <= ST_INS;
                else state <= ST_EMIT;
              end
              mpgt_pkg::OP_BUILD: begin
                res_status <= mpgt_pkg::STAT_PHASE;
                if (!built) begin
                  cur   <= '0;
                  sidx  <= 2'd0;
                  head  <= '0;
                  tail  <= '0;
                  state <= ST_B_RD1;
                end else begin
                  state <= ST_EMIT;
                end
              end
              mpgt_pkg::OP_LOOKUP: begin
                if (built && lk_range) res_status <= mpgt_pkg::STAT_RANGE;
                else res_status <= mpgt_pkg::STAT_PHASE;
                if (built && !lk_range) state <= ST_LK_RD;
                else state <= ST_EMIT;
              end
              default: begin
                res_status <= mpgt_pkg::STAT_PHASE;
                state      <= ST_EMIT;
              end
            endcase
          end
        end
        ST_INS, ST_INS_RD: begin
          if (state == ST_INS && gvalid[ins_slot]) begin
            state <= ST_INS_RD;
          end else begin
            state <= ST_EMIT;
            if (state == ST_INS && full) begin
              // dropped symbol, cursor still returns to root at the word end
              res_status <= mpgt_pkg::STAT_FULL;
              res_next   <= cursor;
              res_mask   <= '0;
              if (it.word_end) cursor <= '0;
            end else begin
              if (state == ST_INS) begin
                gvalid[ins_slot] <= 1'b1;
                nodes_used       <= nodes_used + CW'(1);
              end
              if (it.word_end) begin
                if (kidx_ok) emask[ins_nxt] <= emask[ins_nxt] | (NK'(1) << it.keyword_index);
                cursor <= '0;
              end else begin
                cursor <= ins_nxt;
              end
              res_status <= mpgt_pkg::STAT_OK;
              res_next   <= ins_nxt;
              res_mask   <= '0;
            end
          end
        end
        ST_LK_RD: begin
          res_status <= mpgt_pkg::STAT_OK;
          res_next   <= ram_rdata;
          res_mask   <= emask[ram_rdata];
          state      <= ST_EMIT;
        end
        ST_B_RD1: begin
          state <= ST_B_RD2;
        end
        ST_B_RD2: begin
          // children of the root fail to the root
          fval  <= (cur == '0) ? '0 : ram_rdata;
          state <= ST_B_ACT;
        end
        ST_B_ACT: begin
          if (gvalid[b_slot]) begin
            fail[ram_rdata]        <= fval;
            emask[ram_rdata]       <= emask[ram_rdata] | emask[fval];
            queue[tail[NW-1:0]]    <= ram_rdata;
            tail                   <= tail + CW'(1);
          end else begin
            gvalid[b_slot] <= 1'b1;
          end
          sidx <= sidx + 2'd1;
          if (sidx == 2'd3) state <= ST_B_POP;
          else state <= ST_B_RD1;
        end
        ST_B_POP: begin
          if (head < tail) begin
            cur   <= queue[head[NW-1:0]];
            head  <= head + CW'(1);
            sidx  <= 2'd0;
            state <= ST_B_RD1;
          end else begin
            built      <= 1'b1;
            res_status <= mpgt_pkg::STAT_OK;
            res_next   <= '0;
            res_mask   <= '0;
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            o_status  <= res_status;
            o_next    <= res_next;
            o_mask    <= res_mask;
            o_cnt     <= nodes_used;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign next32     = 32'(o_next);
  assign mask32     = 32'(o_mask);
  assign cnt32      = 32'(o_cnt);
  assign status     = o_status;
  assign next_node  = next32[4:0];
  assign match_mask = mask32[3:0];
  assign node_count = cnt32[5:0];

endmodule

FILE: rtl/multi_pattern_goto_table.sv
// top level of the multi-pattern goto table (keyword automaton)
// lookup: IDLE, LK_RD, EMIT; insert: IDLE, INS, EMIT, plus INS_RD on an existing edge
// phase and range errors: IDLE, EMIT; the engine takes one transaction at a time
// build: B_RD1, B_RD2, B_ACT per node and symbol plus B_POP per node, set by the
//   single read port of the goto ram walked in breadth-first order
// reset clears valid bits, failure links and masks at once; no clearing pass
`timescale 1ns / 1ps

module multi_pattern_goto_table #(
  parameter int MAX_NODES    = mpgt_pkg::MAX_NODES_DEF,
  parameter int NUM_KEYWORDS = mpgt_pkg::NUM_KEYWORDS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [1:0] symbol,
  input  logic       word_end,
  input  logic [1:0] keyword_index,
  input  logic [4:0] from_state,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [4:0] next_node,
  output logic [3:0] match_mask,
  output logic [5:0] node_count
);

  logic            q_valid;
  logic            q_pop;
  mpgt_pkg::item_t q_item;

  mpgt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .symbol        (symbol),
    .word_end      (word_end),
    .keyword_index (keyword_index),
    .from_state    (from_state),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  mpgt_back #(
    .MAX_NODES    (MAX_NODES),
    .NUM_KEYWORDS (NUM_KEYWORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .next_node  (next_node),
    .match_mask (match_mask),
    .node_count (node_count)
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_full_means_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mpgt_pkg::STAT_FULL |-> node_count == 6'(MAX_NODES))
    else $error("table full reported below capacity");

  a_range_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mpgt_pkg::STAT_RANGE |-> next_node == 5'd0 && match_mask == 4'd0)
    else $error("out of range result carries data");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(next_node) &&
      $stable(match_mask) && $stable(node_count))
    else $error("stalled result changed");

endmodule
